/* rtl/core/crc16_frame_builder_core_macros.svh */
// Assertion macros for the crc16 frame builder checker.
// No dependencies; included by the checker file.
`ifndef CRC16_FRAME_BUILDER_CORE_MACROS_SVH
`define CRC16_FRAME_BUILDER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRC16FB_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc16fb check failed");

// next-cycle implication, checked outside reset
`define CRC16FB_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc16fb check failed");

`endif

/* rtl/core/crc16fb_pkg.sv */
// Shared types, constants and CRC function for the crc16 frame builder.
// No dependencies.
package crc16fb_pkg;

    localparam int unsigned MAX_PAYLOAD = 56;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND_RST = 8'h55;

    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       is_start;
        logic       last;      // frame closes with this word
        logic [7:0] data;      // clamped length on start, payload byte otherwise
        logic [7:0] command;
        logic [7:0] sequence_req;
    } entry_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } hdr_t;

    typedef enum logic [2:0] {
        PH_FETCH,
        PH_HDR1,
        PH_LEN,
        PH_CMD,
        PH_SEQ,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/crc16fb_front.sv */
// Front end: config registers, frame tracking, item classification.
// Depends on crc16fb_pkg.
module crc16fb_front
    import crc16fb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       mode,
    input  logic [7:0] command,
    input  logic [7:0] sequence_req,
    input  logic [7:0] payload_length,
    input  logic [7:0] payload_byte,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output logic       q_wr,
    output entry_t     q_data,
    output hdr_t       hdr
);

    logic [7:0] hdr_first_reg;
    logic [7:0] hdr_second_reg;
    logic [5:0] rem_reg;
    logic [5:0] rem_next;
    logic [5:0] len_clamped;
    logic       accept;

    assign accept = push && !q_full;
    assign len_clamped = (payload_length > 8'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD)
                                                            : payload_length[5:0];

    always_comb
    begin
        q_data          = '0;
        q_data.command  = command;
        q_data.sequence_req = sequence_req;
        q_wr            = 1'b0;
        rem_next        = rem_reg;
        if (mode == MODE_START)
        begin
            q_data.is_start = 1'b1;
            q_data.data     = {2'b00, len_clamped};
            q_data.last     = (len_clamped == 6'd0);
            q_wr            = accept;
            if (accept)
                rem_next = len_clamped;
        end
        else
        begin
            q_data.is_start = 1'b0;
            q_data.data     = payload_byte;
            q_data.last     = (rem_reg == 6'd1);
            q_wr            = accept && (rem_reg != 6'd0);   // no open frame: drop
            if (q_wr)
                rem_next = rem_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            hdr_first_reg  <= HDR_FIRST_RST;
            hdr_second_reg <= HDR_SECOND_RST;
        end
        else
        begin
            rem_reg <= rem_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_HEADER_FIRST:  hdr_first_reg  <= cfg_data;
                    CFG_HEADER_SECOND: hdr_second_reg <= cfg_data;
                    default:           hdr_first_reg  <= hdr_first_reg;
                endcase
            end
        end
    end

    assign hdr.first  = hdr_first_reg;
    assign hdr.second = hdr_second_reg;

endmodule

/* rtl/core/crc16fb_queue.sv */
// Small word queue between front end and byte sequencer.
// Depends on crc16fb_pkg.
module crc16fb_queue
    import crc16fb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_data,
    input  logic   rd,
    output entry_t rd_data,
    output logic   q_full,
    output logic   q_empty
);

    entry_t            slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = slots_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/core/crc16fb_back.sv */
// Byte sequencer: expands queued words into frame bytes, runs the CRC,
// holds the output register. Depends on crc16fb_pkg.
module crc16fb_back
    import crc16fb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head,
    input  logic       q_empty,
    output logic       q_rd,
    input  hdr_t       hdr,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       frame_end
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_base;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;

    logic        room;
    logic        adv;
    logic [7:0]  byte_sel;
    logic        feed;
    logic        is_end;
    logic        done;

    assign room = !out_valid_reg || pop;
    assign adv  = ((phase_reg != PH_FETCH) || !q_empty) && room;

    // byte select per phase
    always_comb
    begin
        byte_sel = 8'h00;
        feed     = 1'b1;
        is_end   = 1'b0;
        done     = 1'b0;
        case (phase_reg)
            PH_FETCH:
            begin
                byte_sel = head.is_start ? hdr.first : head.data;
                done     = !head.is_start && !head.last;
            end
            PH_HDR1:   byte_sel = hdr.second;
            PH_LEN:    byte_sel = head.data;
            PH_CMD:    byte_sel = head.command;
            PH_SEQ:
            begin
                byte_sel = head.sequence_req;
                done     = !head.last;
            end
            PH_CRC_HI:
            begin
                byte_sel = crc_reg[15:8];
                feed     = 1'b0;
            end
            PH_CRC_LO:
            begin
                byte_sel = crc_reg[7:0];
                feed     = 1'b0;
                is_end   = 1'b1;
                done     = 1'b1;
            end
            default:
            begin
                byte_sel = 8'h00;
                feed     = 1'b0;
            end
        endcase
    end

    assign q_rd     = adv && done;
    assign crc_base = (phase_reg == PH_FETCH && head.is_start) ? CRC_INIT : crc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (adv)
        begin
            case (phase_reg)
                PH_FETCH:
                begin
                    if (head.is_start)
                        phase_next = PH_HDR1;
                    else if (head.last)
                        phase_next = PH_CRC_HI;
                    else
                        phase_next = PH_FETCH;
                end
                PH_HDR1:   phase_next = PH_LEN;
                PH_LEN:    phase_next = PH_CMD;
                PH_CMD:    phase_next = PH_SEQ;
                PH_SEQ:    phase_next = head.last ? PH_CRC_HI : PH_FETCH;
                PH_CRC_HI: phase_next = PH_CRC_LO;
                PH_CRC_LO: phase_next = PH_FETCH;
                default:   phase_next = PH_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FETCH;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                if (feed)
                    crc_reg <= crc16_byte(crc_base, byte_sel);
                else if (is_end)
                    crc_reg <= CRC_INIT;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= byte_sel;
            out_end_reg  <= is_end;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = out_end_reg;

endmodule

/* rtl/core/crc16_frame_builder_core.sv */
// Top level of the CRC-16 frame builder.
// Depends on crc16fb_pkg, crc16fb_front, crc16fb_queue, crc16fb_back.
//
//  channel | handshake       | payload
//  --------+-----------------+--------------------------------------------------
//  items   | push / full     | mode, command, sequence_req, payload_length,
//          |                 | payload_byte
//  bytes   | empty / pop     | out_byte, frame_end
//  config  | cfg_we          | cfg_addr, cfg_data
//
// One item can be accepted every cycle while the queue has room; one byte leaves
// per cycle while pop takes each. A payload item yields one byte, three when it
// closes the frame; a start item five, seven with zero length. The byte sequencer
// and its output register set the rate; items go via the queue to that register.
// Reset clears the queue, frame state and output register; headers go to 0xAA/0x55.
module crc16_frame_builder_core
    import crc16fb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       mode,
    input  logic [7:0] command,
    input  logic [7:0] sequence_req,
    input  logic [7:0] payload_length,
    input  logic [7:0] payload_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       frame_end,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_data
);

    logic   q_wr;
    logic   q_rd;
    logic   q_full;
    logic   q_empty;
    entry_t q_wdata;
    entry_t q_head;
    hdr_t   hdr;

    assign full = q_full;

    crc16fb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .mode           (mode),
        .command        (command),
        .sequence_req   (sequence_req),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .q_data         (q_wdata),
        .hdr            (hdr)
    );

    crc16fb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .rd      (q_rd),
        .rd_data (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    crc16fb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .hdr       (hdr),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule

/* rtl/core/crc16fb_checker.sv */
// Port-level checks for crc16_frame_builder_core, bound to the top level.
// Depends on crc16_frame_builder_core_macros.svh.
`include "crc16_frame_builder_core_macros.svh"

module crc16fb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       frame_end
);

    `CRC16FB_AST_NXT(a_out_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(frame_end))
    `CRC16FB_AST_NOW(a_full_from_push, $rose(full), $past(push))
    `CRC16FB_AST_NOW(a_empty_from_pop, $rose(empty), $past(pop))
    `CRC16FB_AST_NXT(a_end_not_twice, !empty && frame_end && pop, empty || !frame_end)

endmodule

bind crc16_frame_builder_core crc16fb_checker u_crc16fb_checker (.*);
